FILE: hw/rtl/takf_pkg.sv
// Shared types, constants and helper functions for the tilt-angle Kalman filter.
package takf_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned PROD_W   = 66;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_Q_ANGLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Q_GYRO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R_ANGLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

    localparam logic [24:0] RST_Q_ANGLE   = 25'd16777;
    localparam logic [24:0] RST_Q_GYRO    = 25'd50332;
    localparam logic [28:0] RST_R_ANGLE   = 29'd8388608;
    localparam logic [24:0] RST_TIME_STEP = 25'd83886;
    localparam logic signed [WORD_W-1:0] COV_ONE = 32'sd16777216;

    localparam int unsigned DIV_W = 58;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_ANG,
        ST_M_P00,
        ST_M_P01,
        ST_M_P11,
        ST_ANG,
        ST_DIV0_GO,
        ST_DIV0_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_M_N00,
        ST_M_N01,
        ST_M_N10,
        ST_M_N11,
        ST_M_UA,
        ST_M_UB,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic              negate;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [WORD_W-1:0] r;
        if (x > 66'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (x < -66'sh0_8000_0000)
            r = 32'sh8000_0000;
        else
            r = x[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd24(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + 66'sd8388608;
        return t >>> FRAC_W;
    endfunction

endpackage

FILE: hw/rtl/takf_div.sv
// Restoring divider, one quotient bit per cycle, for the Kalman gains.
module takf_div
    import takf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_div_req                 i_req,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_gain
);

    localparam int unsigned CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem,  n_rem;
    logic [DIV_W-1:0] r_quo,  n_quo;
    logic [DIV_W-1:0] r_den,  n_den;
    logic             r_neg,  n_neg;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DIV_W:0]   w_trial;
    logic signed [PROD_W-1:0] w_q;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[DIV_W-1]};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
            n_neg  = i_req.negate;
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W);
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = DIV_W'(w_trial - {1'b0, r_den});
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    always_comb begin
        w_q = r_neg ? -$signed({8'd0, r_quo}) : $signed({8'd0, r_quo});
    end

    assign o_done = r_done;
    assign o_gain = sat32(w_q);

endmodule

FILE: hw/rtl/tilt_angle_kalman_filter.sv
// Top level of the tilt-angle Kalman filter: sequencer, shared multiplier and state.
// Each of the ten products of a sample pair passes through one shared 34x33 signed
// multiplier, one product a cycle. The two gains come from one restoring divider that
// yields one quotient bit a cycle, with a start step before the quotient bits and a
// finish step after them. When the denominator is not positive both divisions are
// skipped and the gains stay zero. The input is not ready while a sample is in work. A
// finished result waits in the output register, and the next sample can be taken while
// it waits. The sequencer holds at its last step only while an earlier result has not
// yet been taken.
module tilt_angle_kalman_filter
    import takf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,   // [31:0] rate_sample, [55:32] measured_angle
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [31:0] angle_estimate, [63:32] bias_estimate
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_state r_state, n_state;

    logic [24:0] r_q_angle, r_q_gyro, r_dt;
    logic [28:0] r_r_angle;

    logic signed [WORD_W-1:0] r_ang, r_bias, r_paa, r_pab, r_pba, r_pbb;
    logic signed [WORD_W-1:0] r_p00, r_p01, r_p10, r_p11, r_k0, r_k1, r_err;
    logic signed [WORD_W-1:0] r_rate;
    logic signed [23:0]       r_meas;
    logic                     r_oval;
    logic [63:0]              r_odata;

    logic signed [33:0]       w_ma;
    logic signed [32:0]       w_mb;
    logic signed [PROD_W-1:0] w_prod, w_rnd;
    logic signed [PROD_W-1:0] w_e;
    logic [PROD_W-1:0]        w_pabs;
    t_div_req                 w_div;
    logic                     w_div_done;
    logic signed [WORD_W-1:0] w_gain;

    logic                     w_accept;
    logic                     w_out_free;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_oval || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle <= RST_Q_ANGLE;
            r_q_gyro  <= RST_Q_GYRO;
            r_r_angle <= RST_R_ANGLE;
            r_dt      <= RST_TIME_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_Q_ANGLE:   r_q_angle <= i_cfg_data[24:0];
                REG_Q_GYRO:    r_q_gyro  <= i_cfg_data[24:0];
                REG_R_ANGLE:   r_r_angle <= i_cfg_data[28:0];
                REG_TIME_STEP: r_dt      <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_M_ANG: begin
                w_ma = 34'(r_rate) - 34'(r_bias);
                w_mb = $signed({8'd0, r_dt});
            end
            ST_M_P00: begin
                w_ma = $signed({9'd0, r_q_angle}) - 34'(r_pab) - 34'(r_pba);
                w_mb = $signed({8'd0, r_dt});
            end
            ST_M_P01: begin
                w_ma = -34'(r_pbb);
                w_mb = $signed({8'd0, r_dt});
            end
            ST_M_P11: begin
                w_ma = $signed({9'd0, r_q_gyro});
                w_mb = $signed({8'd0, r_dt});
            end
            ST_M_N00: begin w_ma = 34'(r_k0); w_mb = 33'(r_p00); end
            ST_M_N01: begin w_ma = 34'(r_k0); w_mb = 33'(r_p01); end
            ST_M_N10: begin w_ma = 34'(r_k1); w_mb = 33'(r_p00); end
            ST_M_N11: begin w_ma = 34'(r_k1); w_mb = 33'(r_p01); end
            ST_M_UA:  begin w_ma = 34'(r_k0); w_mb = 33'(r_err); end
            ST_M_UB:  begin w_ma = 34'(r_k1); w_mb = 33'(r_err); end
            default: ;
        endcase
    end

    assign w_prod = PROD_W'(w_ma) * PROD_W'(w_mb);
    assign w_rnd  = rnd24(w_prod);
    assign w_e    = PROD_W'(r_p00) + $signed({37'd0, r_r_angle});

    always_comb begin
        w_div.start    = 1'b0;
        w_div.negate   = 1'b0;
        w_div.divisor  = w_e[DIV_W-1:0];
        w_div.dividend = '0;
        w_pabs         = '0;
        if (r_state == ST_DIV0_GO || r_state == ST_DIV1_GO) begin
            w_pabs = (r_state == ST_DIV0_GO) ? PROD_W'(r_p00) : PROD_W'(r_p10);
            w_div.negate = w_pabs[PROD_W-1];
            if (w_pabs[PROD_W-1])
                w_pabs = -w_pabs;
            w_div.dividend = DIV_W'(w_pabs << FRAC_W);
            w_div.start = (w_e > 0);
        end
    end

    takf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .o_done  (w_div_done),
        .o_gain  (w_gain)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_M_ANG;
            ST_M_ANG:     n_state = ST_M_P00;
            ST_M_P00:     n_state = ST_M_P01;
            ST_M_P01:     n_state = ST_M_P11;
            ST_M_P11:     n_state = ST_ANG;
            ST_ANG:       n_state = ST_DIV0_GO;
            ST_DIV0_GO:   n_state = (w_e > 0) ? ST_DIV0_WAIT : ST_M_N00;
            ST_DIV0_WAIT: if (w_div_done) n_state = ST_DIV1_GO;
            ST_DIV1_GO:   n_state = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (w_div_done) n_state = ST_M_N00;
            ST_M_N00:     n_state = ST_M_N01;
            ST_M_N01:     n_state = ST_M_N10;
            ST_M_N10:     n_state = ST_M_N11;
            ST_M_N11:     n_state = ST_M_UA;
            ST_M_UA:      n_state = ST_M_UB;
            ST_M_UB:      n_state = ST_OUT;
            ST_OUT:       n_state = w_out_free ? ST_IDLE : ST_OUT;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= ST_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_paa  <= COV_ONE;
            r_pab  <= '0;
            r_pba  <= '0;
            r_pbb  <= COV_ONE;
            r_oval <= 1'b0;
        end else begin
            case (r_state)
                ST_M_ANG: r_ang <= sat32(PROD_W'(r_ang) + w_rnd);
                ST_M_P00: r_p00 <= sat32(PROD_W'(r_paa) + w_rnd);
                ST_M_P01: begin
                    r_p01 <= sat32(PROD_W'(r_pab) + w_rnd);
                    r_p10 <= sat32(PROD_W'(r_pba) + w_rnd);
                end
                ST_M_P11: r_p11 <= sat32(PROD_W'(r_pbb) + w_rnd);
                ST_ANG: begin
                    r_err <= sat32(PROD_W'(r_meas) - PROD_W'(r_ang));
                    r_k0  <= '0;
                    r_k1  <= '0;
                end
                ST_DIV0_WAIT: if (w_div_done) r_k0 <= w_gain;
                ST_DIV1_WAIT: if (w_div_done) r_k1 <= w_gain;
                ST_M_N00: r_paa <= sat32(PROD_W'(r_p00) - w_rnd);
                ST_M_N01: r_pab <= sat32(PROD_W'(r_p01) - w_rnd);
                ST_M_N10: r_pba <= sat32(PROD_W'(r_p10) - w_rnd);
                ST_M_N11: r_pbb <= sat32(PROD_W'(r_p11) - w_rnd);
                ST_M_UA:  r_ang  <= sat32(PROD_W'(r_ang) + w_rnd);
                ST_M_UB:  r_bias <= sat32(PROD_W'(r_bias) + w_rnd);
                default: ;
            endcase
            if (r_state == ST_OUT && w_out_free)
                r_oval <= 1'b1;
            else if (m_axis_tready)
                r_oval <= 1'b0;
        end
        if (w_accept) begin
            r_rate <= s_axis_tdata[31:0];
            r_meas <= s_axis_tdata[55:32];
        end
        if (r_state == ST_OUT && w_out_free)
            r_odata <= {r_bias, r_ang};
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV0_WAIT || r_state == ST_DIV1_WAIT))
        else $error("divider done out of step");

endmodule
